// ===== design/lwpw_pkg.sv =====
// Shared types and constants for the LCD window pixel writer.
package lwpw_pkg;

  // Screen size in pixels; positions at or beyond these are not written.
  localparam int unsigned ScreenWidth  = 128;
  localparam int unsigned ScreenHeight = 128;

  localparam int unsigned COORD_W     = 9;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned PIXEL_W     = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  // Register values after reset.
  localparam logic [6:0] LEFT_RESET   = 7'd0;
  localparam logic [6:0] TOP_RESET    = 7'd0;
  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [7:0] HEIGHT_RESET = 8'd128;

  // Scan orders; the unused code behaves as normal.
  typedef enum logic [1:0] {
    SCAN_NORMAL  = 2'd0,
    SCAN_FLIPPED = 2'd1,
    SCAN_ROTATED = 2'd2
  } scan_mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_LEFT   = 3'd0,
    CFG_WINDOW_TOP    = 3'd1,
    CFG_WINDOW_WIDTH  = 3'd2,
    CFG_WINDOW_HEIGHT = 3'd3,
    CFG_SCAN_MODE     = 3'd4
  } cfg_reg_e;

  // Cursor status handed from the cursor unit to the formatter.
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               done;
  } cursor_t;

  // One frame memory write result.
  typedef struct packed {
    logic       write_valid;
    logic [6:0] write_column;
    logic [6:0] write_row;
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
  } result_t;

endpackage

// ===== design/lwpw_cursor.sv =====
// Window registers and the write cursor that walks the window in scan order.
module lwpw_cursor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lwpw_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [lwpw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             step_i,
  output lwpw_pkg::cursor_t                cursor_o
);
  import lwpw_pkg::*;

  logic [6:0]         left_q, left_d;
  logic [6:0]         top_q, top_d;
  logic [7:0]         width_q, width_d;
  logic [7:0]         height_q, height_d;
  logic [1:0]         mode_q, mode_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [COORD_W-1:0] row_q, row_d;
  logic               done_q, done_d;
  logic               cfg_hit;
  logic [COORD_W-1:0] right_new, bottom_new;
  logic [COORD_W-1:0] right_cur, bottom_cur;

  // Register writes; an index past the last register is ignored.
  always_comb begin
    left_d   = left_q;
    top_d    = top_q;
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LEFT: begin
          left_d  = cfg_data_i[6:0];
          cfg_hit = 1'b1;
        end
        CFG_WINDOW_TOP: begin
          top_d   = cfg_data_i[6:0];
          cfg_hit = 1'b1;
        end
        CFG_WINDOW_WIDTH: begin
          width_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        CFG_WINDOW_HEIGHT: begin
          height_d = cfg_data_i;
          cfg_hit  = 1'b1;
        end
        CFG_SCAN_MODE: begin
          mode_d  = cfg_data_i[1:0];
          cfg_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Window edges in nine bits, for the new and the current register values.
  assign right_new  = {2'b00, left_d} + {1'b0, width_d} - 9'd1;
  assign bottom_new = {2'b00, top_d} + {1'b0, height_d} - 9'd1;
  assign right_cur  = {2'b00, left_q} + {1'b0, width_q} - 9'd1;
  assign bottom_cur = {2'b00, top_q} + {1'b0, height_q} - 9'd1;

  // Next cursor: reload to the start corner on a write to a known register, else advance on a step until done.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    done_d = done_q;
    if (cfg_hit) begin
      col_d  = {2'b00, left_d};
      row_d  = {2'b00, top_d};
      done_d = (width_d == 8'd0) || (height_d == 8'd0);
      if (mode_d == SCAN_ROTATED) begin
        row_d = bottom_new;
      end else if (mode_d == SCAN_FLIPPED) begin
        col_d = right_new;
        row_d = bottom_new;
      end
    end else if (step_i && !done_q) begin
      if (mode_q == SCAN_ROTATED) begin
        // Bottom to top, then one column right.
        if (row_q == {2'b00, top_q}) begin
          row_d = bottom_cur;
          if (col_q == right_cur) begin
            done_d = 1'b1;
          end else begin
            col_d = col_q + 9'd1;
          end
        end else begin
          row_d = row_q - 9'd1;
        end
      end else if (mode_q == SCAN_FLIPPED) begin
        // Right to left, then one row up.
        if (col_q == {2'b00, left_q}) begin
          col_d = right_cur;
          if (row_q == {2'b00, top_q}) begin
            done_d = 1'b1;
          end else begin
            row_d = row_q - 9'd1;
          end
        end else begin
          col_d = col_q - 9'd1;
        end
      end else begin
        // Left to right, then one row down.
        if (col_q == right_cur) begin
          col_d = {2'b00, left_q};
          if (row_q == bottom_cur) begin
            done_d = 1'b1;
          end else begin
            row_d = row_q + 9'd1;
          end
        end else begin
          col_d = col_q + 9'd1;
        end
      end
    end
  end

  // Register and cursor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= LEFT_RESET;
      top_q    <= TOP_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      mode_q   <= SCAN_NORMAL;
      col_q    <= {2'b00, LEFT_RESET};
      row_q    <= {2'b00, TOP_RESET};
      done_q   <= 1'b0;
    end else begin
      left_q   <= left_d;
      top_q    <= top_d;
      width_q  <= width_d;
      height_q <= height_d;
      mode_q   <= mode_d;
      col_q    <= col_d;
      row_q    <= row_d;
      done_q   <= done_d;
    end
  end

  assign cursor_o.column = col_q;
  assign cursor_o.row    = row_q;
  assign cursor_o.done   = done_q;

endmodule

// ===== design/lwpw_pixel_fmt.sv =====
// Expands an RGB565 pixel and forms the write at the current cursor.
module lwpw_pixel_fmt (
  input  logic [lwpw_pkg::PIXEL_W-1:0] pixel_i,
  input  lwpw_pkg::cursor_t            cursor_i,
  output lwpw_pkg::result_t            result_o
);
  import lwpw_pkg::*;

  logic on_screen;

  // A position off the screen is skipped but still consumes a pixel.
  assign on_screen = ({1'b0, cursor_i.column} < 10'(ScreenWidth)) &&
                     ({1'b0, cursor_i.row} < 10'(ScreenHeight));

  // A dropped pixel gives an all-zero word.
  always_comb begin
    result_o = '0;
    if (!cursor_i.done && on_screen) begin
      result_o.write_valid  = 1'b1;
      result_o.write_column = cursor_i.column[6:0];
      result_o.write_row    = cursor_i.row[6:0];
      result_o.red_byte     = {pixel_i[15:11], 3'b000};
      result_o.green_byte   = {pixel_i[10:5], 2'b00};
      result_o.blue_byte    = {pixel_i[4:0], 3'b000};
    end
  end

endmodule

// ===== design/lwpw_out_reg.sv =====
// Output register that holds a result word until the sink takes it.
module lwpw_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lwpw_pkg::result_t result_i,
  input  logic              take_i,
  output logic              ready_o,
  output logic              valid_o,
  output lwpw_pkg::result_t result_o
);
  import lwpw_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Room for a new word when empty or when the held word leaves this cycle.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== design/lcd_window_pixel_writer_core.sv =====
// Top level of the LCD window pixel writer: cursor, formatter and output register.
// An accepted pixel's write word is registered and on the output in the next cycle.
// Throughput: one pixel per cycle while the sink takes each word; the cursor compare and step are combinational.
// A pixel is taken while a held word leaves in the same cycle.
// Reset (asynchronous, active low) sets the full 128 by 128 window in normal
// order with the cursor at its top left corner and the output empty.
module lcd_window_pixel_writer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lwpw_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [lwpw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_rgb565
  input  logic [lwpw_pkg::PIXEL_W-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // write_column, write_row, red_byte, green_byte, blue_byte, two zero bits
  output logic [lwpw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // write_valid
  output logic                             m_axis_tuser
);
  import lwpw_pkg::*;

  logic    in_accept;
  logic    out_take;
  cursor_t cursor;
  result_t result_new;
  result_t result_out;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_take  = m_axis_tvalid && m_axis_tready;

  lwpw_cursor u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_accept),
    .cursor_o    (cursor)
  );

  lwpw_pixel_fmt u_pixel_fmt (
    .pixel_i  (s_axis_tdata),
    .cursor_i (cursor),
    .result_o (result_new)
  );

  lwpw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_accept),
    .result_i (result_new),
    .take_i   (out_take),
    .ready_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .result_o (result_out)
  );

  // Pack the output word, first field in the lowest bits.
  assign m_axis_tdata = {2'b00, result_out.blue_byte, result_out.green_byte,
                         result_out.red_byte, result_out.write_row,
                         result_out.write_column};
  assign m_axis_tuser = result_out.write_valid;

endmodule

// ===== design/lwpw_checker.sv =====
// Port-level checks for the LCD window pixel writer, bound to the top level.
module lwpw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lwpw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);
  import lwpw_pkg::*;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // A dropped pixel carries an all-zero word.
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("dropped pixel with nonzero data");

  // An empty output stage always takes a pixel.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Every accepted pixel shows a word in the next cycle.
  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted pixel produced no word");

endmodule

bind lcd_window_pixel_writer_core lwpw_checker u_lwpw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the LCD window pixel writer core.
module testbench;
  import lwpw_pkg::*;

  // Register indexes past the last register, and the scan code with no mode.
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_LAST  = '1;
  localparam logic [1:0]             SCAN_SPARE      = 2'd3;
  localparam int unsigned            RANDOM_PIXELS   = 1050;
  localparam int unsigned            QUIET_AFTER     = 900;

  // Predicts each frame memory write and checks the words that leave the block.
  class pixel_write_scoreboard;
    logic [6:0]  win_left;
    logic [6:0]  win_top;
    logic [7:0]  win_width;
    logic [7:0]  win_height;
    logic [1:0]  scan;
    logic [8:0]  cur_col;
    logic [8:0]  cur_row;
    bit          walk_done;
    result_t     pending_writes[$];
    int unsigned mismatches;
    int unsigned pixels_written;
    int unsigned pixels_dropped;
    int unsigned mode_pixels[4];

    function new();
      win_left   = LEFT_RESET;
      win_top    = TOP_RESET;
      win_width  = WIDTH_RESET;
      win_height = HEIGHT_RESET;
      scan       = SCAN_NORMAL;
      restart_walk();
    endfunction

    function logic [8:0] right_col();
      return {2'b00, win_left} + {1'b0, win_width} - 9'd1;
    endfunction

    function logic [8:0] bottom_row();
      return {2'b00, win_top} + {1'b0, win_height} - 9'd1;
    endfunction

    // Put the cursor on the start corner of the current scan order.
    function void restart_walk();
      cur_col   = {2'b00, win_left};
      cur_row   = {2'b00, win_top};
      walk_done = (win_width == 0) || (win_height == 0);
      if (!walk_done) begin
        if (scan == SCAN_ROTATED) begin
          cur_row = bottom_row();
        end else if (scan == SCAN_FLIPPED) begin
          cur_col = right_col();
          cur_row = bottom_row();
        end
      end
    endfunction

    // Any known register reloads the cursor; spare indexes change nothing.
    function void reg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_WINDOW_LEFT:   win_left   = value[6:0];
        CFG_WINDOW_TOP:    win_top    = value[6:0];
        CFG_WINDOW_WIDTH:  win_width  = value;
        CFG_WINDOW_HEIGHT: win_height = value;
        CFG_SCAN_MODE:     scan       = value[1:0];
        default:           return;
      endcase
      restart_walk();
    endfunction

    // Work out the write for one accepted pixel, then step the cursor.
    function void note_pixel(logic [PIXEL_W-1:0] px);
      result_t r;
      r = '0;
      mode_pixels[scan]++;
      if (!walk_done) begin
        if (cur_col < ScreenWidth && cur_row < ScreenHeight) begin
          r.write_valid  = 1'b1;
          r.write_column = cur_col[6:0];
          r.write_row    = cur_row[6:0];
          r.red_byte     = {px[15:11], 3'b000};
          r.green_byte   = {px[10:5], 2'b00};
          r.blue_byte    = {px[4:0], 3'b000};
        end
        if (scan == SCAN_ROTATED) begin
          if (cur_row == {2'b00, win_top}) begin
            cur_row = bottom_row();
            if (cur_col == right_col()) walk_done = 1'b1;
            else cur_col++;
          end else begin
            cur_row--;
          end
        end else if (scan == SCAN_FLIPPED) begin
          if (cur_col == {2'b00, win_left}) begin
            cur_col = right_col();
            if (cur_row == {2'b00, win_top}) walk_done = 1'b1;
            else cur_row--;
          end else begin
            cur_col--;
          end
        end else begin
          if (cur_col == right_col()) begin
            cur_col = {2'b00, win_left};
            if (cur_row == bottom_row()) walk_done = 1'b1;
            else cur_row++;
          end else begin
            cur_col++;
          end
        end
      end
      if (r.write_valid) pixels_written++;
      else pixels_dropped++;
      pending_writes.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one write word with the oldest prediction.
    function void check_write(logic user, logic [OUT_TDATA_W-1:0] data);
      result_t want;
      if (pending_writes.size() == 0) begin
        $error("write word with none expected: tuser %0b, tdata %h", user, data);
        mismatches++;
        return;
      end
      want = pending_writes.pop_front();
      compare_field("write_valid", want.write_valid, user);
      compare_field("write_column", want.write_column, data[6:0]);
      compare_field("write_row", want.write_row, data[13:7]);
      compare_field("red_byte", want.red_byte, data[21:14]);
      compare_field("green_byte", want.green_byte, data[29:22]);
      compare_field("blue_byte", want.blue_byte, data[37:30]);
      compare_field("tdata padding", 0, data[39:38]);
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIXEL_W-1:0]     s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  pixel_write_scoreboard sb = new();
  int unsigned idle_pct;
  int unsigned stall_left;
  int unsigned setups;

  lcd_window_pixel_writer_core uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #4000000;
    $display("Run limit reached with %0d writes outstanding.", sb.pending_writes.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Observe register writes and both word handshakes at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.reg_write(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_write(m_axis_tuser, m_axis_tdata);
    end
  end

  // Receiver side: ready drops in random bursts while idling is enabled.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 9);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
  endtask

  task automatic close_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one pixel, maybe after a random gap, and wait until it is taken.
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stream_pixels(input int unsigned count);
    repeat (count) send_pixel(16'($urandom));
  endtask

  // Stop offering and wait, within a limit, until every predicted write has come out.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_writes.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned area;
    int unsigned count;
    int unsigned pick;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  d;

    random_sent = 0;
    idle_pct    = 20;
    stall_left  = 0;
    setups      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window: color extremes and each channel alone.
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    wait_drained();

    // Flipped window hanging over the bottom right screen corner, walked past its end.
    write_reg(CFG_WINDOW_LEFT, 8'hFE);
    write_reg(CFG_WINDOW_TOP, 8'h7F);
    write_reg(CFG_WINDOW_WIDTH, 8'd3);
    write_reg(CFG_WINDOW_HEIGHT, 8'd2);
    write_reg(CFG_SCAN_MODE, {6'b0, SCAN_FLIPPED});
    close_writes();
    stream_pixels(7);
    wait_drained();

    // Rotated 2 by 2 window at the origin, one pixel past the end.
    write_reg(CFG_WINDOW_LEFT, 8'd0);
    write_reg(CFG_WINDOW_TOP, 8'd0);
    write_reg(CFG_WINDOW_WIDTH, 8'd2);
    write_reg(CFG_WINDOW_HEIGHT, 8'd2);
    write_reg(CFG_SCAN_MODE, {6'b0, SCAN_ROTATED});
    close_writes();
    stream_pixels(5);
    wait_drained();

    // Empty window drops everything.
    write_reg(CFG_WINDOW_HEIGHT, 8'd0);
    close_writes();
    stream_pixels(2);
    wait_drained();

    // A spare register index must not reload the cursor mid-window.
    write_reg(CFG_WINDOW_HEIGHT, 8'd1);
    close_writes();
    stream_pixels(1);
    wait_drained();
    write_reg(CFG_INDEX_SPARE, 8'h55);
    close_writes();
    stream_pixels(2);
    wait_drained();

    // Unused scan code with an oversized window running off the right side.
    write_reg(CFG_WINDOW_LEFT, 8'd100);
    write_reg(CFG_WINDOW_WIDTH, 8'd255);
    write_reg(CFG_WINDOW_HEIGHT, 8'd128);
    write_reg(CFG_SCAN_MODE, {6'b111111, SCAN_SPARE});
    close_writes();
    stream_pixels(3);
    wait_drained();
    setups = 6;

    // Random window setups, mostly walked through to the end and a little beyond.
    while (random_sent < RANDOM_PIXELS) begin
      if (random_sent >= QUIET_AFTER) begin
        idle_pct = 0;
      end else begin
        pick = $urandom_range(0, 2);
        idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      end
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        d = 8'($urandom);
        if (pick == 19) begin
          idx = CFG_INDEX_W'($urandom_range(CFG_INDEX_SPARE, CFG_INDEX_LAST));
        end else begin
          idx = CFG_INDEX_W'(pick % 5);
          case (idx)
            CFG_WINDOW_LEFT, CFG_WINDOW_TOP: begin
              if ($urandom_range(0, 3) == 0) d[6:0] = 7'($urandom_range(112, 127));
            end
            CFG_WINDOW_WIDTH, CFG_WINDOW_HEIGHT: begin
              pick = $urandom_range(0, 15);
              if (pick == 0) d = 8'd0;
              else if (pick == 1) d = 8'd128;
              else if (pick == 2) d = 8'd255;
              else if (pick > 3) d = 8'($urandom_range(1, 8));
            end
            default: d[1:0] = 2'($urandom_range(0, 3));
          endcase
        end
        write_reg(idx, d);
      end
      close_writes();
      area  = int'(sb.win_width) * int'(sb.win_height);
      if (area == 0) count = $urandom_range(1, 3);
      else if (area <= 48) count = area + $urandom_range(0, 3);
      else count = $urandom_range(8, 48);
      stream_pixels(count);
      random_sent += count;
      setups++;
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (sb.pending_writes.size() != 0) begin
      $error("%0d predicted writes never arrived", sb.pending_writes.size());
      sb.mismatches++;
    end
    $display("Streamed %0d pixels over %0d window setups: %0d written, %0d dropped.",
             sb.pixels_written + sb.pixels_dropped, setups, sb.pixels_written,
             sb.pixels_dropped);
    $display("Pixels per scan code: normal %0d, flipped %0d, rotated %0d, spare %0d.",
             sb.mode_pixels[0], sb.mode_pixels[1], sb.mode_pixels[2], sb.mode_pixels[3]);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
